### rtl/mtf_pkg.sv
// Shared constants and types for the move-to-front coder.
package mtf_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int LEAF_N      = 1 << IDX_W;
    localparam int CNT_W       = $clog2(IDX_W + 1);

    typedef logic [BYTE_W-1:0] sym_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // One entry of the first-match search tree.
    typedef struct packed {
        logic found;
        idx_t idx;
        sym_t sym;
    } node_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic shift;    // move selected symbol to front
        logic clear;    // reload identity
        logic decode;   // match on position instead of symbol
        idx_t pos;      // old position of the moved symbol
        sym_t sym;      // symbol entering at the front
        sym_t key_sym;  // symbol searched for (encode)
        idx_t key_idx;  // position searched for (decode)
    } cell_ctl_t;

endpackage

### rtl/mtf_cell.sv
// One table entry of the move-to-front chain: match and shift logic.
module mtf_cell
(
    input  logic              clk,
    input  logic              rst_n,
    input  mtf_pkg::idx_t     cell_idx,   // tied to this cell's position
    input  mtf_pkg::cell_ctl_t ctl,
    input  mtf_pkg::sym_t     prev_entry, // left neighbor (front symbol for cell 0)
    output mtf_pkg::sym_t     entry,
    output logic              match
);

    mtf_pkg::sym_t entry_reg;
    mtf_pkg::sym_t entry_next;

    assign entry = entry_reg;
    assign match = ctl.decode ? (cell_idx == ctl.key_idx) : (entry_reg == ctl.key_sym);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.clear)
        begin
            entry_next = mtf_pkg::sym_t'(cell_idx);
        end
        else if (ctl.shift && (cell_idx <= ctl.pos))
        begin
            entry_next = prev_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= mtf_pkg::sym_t'(cell_idx);
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

### rtl/mtf_tree.sv
// Registered binary tree picking the lowest matching cell.
module mtf_tree
(
    input  logic          clk,
    input  mtf_pkg::node_t leaf [mtf_pkg::LEAF_N],
    output mtf_pkg::node_t root
);

    // Heap order: node n has children 2n and 2n+1; indexes at or above LEAF_N are leaves.
    mtf_pkg::node_t node_reg [1:mtf_pkg::LEAF_N-1];

    genvar n;
    generate
        for (n = 1; n < mtf_pkg::LEAF_N; n++)
        begin : g_node
            mtf_pkg::node_t lo;
            mtf_pkg::node_t hi;
            if (2 * n >= mtf_pkg::LEAF_N)
            begin : g_leaf_kids
                assign lo = leaf[2 * n - mtf_pkg::LEAF_N];
                assign hi = leaf[2 * n + 1 - mtf_pkg::LEAF_N];
            end
            else
            begin : g_node_kids
                assign lo = node_reg[2 * n];
                assign hi = node_reg[2 * n + 1];
            end

            always_ff @(posedge clk)
            begin
                node_reg[n] <= lo.found ? lo : hi;
            end
        end
    endgenerate

    assign root = node_reg[1];

endmodule

### rtl/move_to_front_coder.sv
// Top level of the byte-wise move-to-front coder.
//
// Move-to-front coder over a TABLE_DEPTH-entry (256) byte table held in a row of cells,
// one entry per cell. cfg_data[0] selects the mode (0 encode symbol->rank, 1 decode
// rank->symbol); write it only while no item is in flight. A new item is taken only
// after the previous one has loaded its result. Its key is registered and broadcast,
// the registered first-match tree settles over all cells, and once the output register
// is free the table shifts and the result is loaded. The output register lets the next
// item be accepted while a result waits on m_tready. An item with tlast set returns the
// table to the identity after its result is computed. In encode mode a symbol not in
// the table reports rank TABLE_DEPTH-1 and enters at the front; ranks at or past
// TABLE_DEPTH saturate to TABLE_DEPTH-1 in decode mode.
module move_to_front_coder
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,     // [0] decode_mode

    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,      // [7:0] in_byte
    input  logic       s_tlast,      // block_last

    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,      // [7:0] out_byte
    output logic       m_tlast       // out_last
);

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SEARCH
    } state_t;

    state_t             state_reg;
    mtf_pkg::cnt_t      cnt_reg;
    logic               decode_reg;
    mtf_pkg::sym_t      key_sym_reg;
    mtf_pkg::idx_t      key_idx_reg;
    logic               last_reg;
    logic               m_tvalid_reg;
    logic [7:0]         m_tdata_reg;
    logic               m_tlast_reg;

    mtf_pkg::cell_ctl_t ctl;
    mtf_pkg::sym_t      entry [mtf_pkg::TABLE_DEPTH];
    logic               match [mtf_pkg::TABLE_DEPTH];
    mtf_pkg::node_t     leaf  [mtf_pkg::LEAF_N];
    mtf_pkg::node_t     root;

    logic               in_fire;
    logic               out_free;
    logic               commit;
    mtf_pkg::idx_t      pos_c;
    mtf_pkg::sym_t      sym_c;
    mtf_pkg::idx_t      in_idx;

    // Config is always writable; the caller keeps it to idle periods.
    assign cfg_ready = 1'b1;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign commit   = (state_reg == ST_SEARCH) && (cnt_reg == mtf_pkg::cnt_t'(mtf_pkg::IDX_W))
                      && out_free;

    // Decode ranks past the table end saturate to the last entry.
    assign in_idx = ({1'b0, s_tdata} >= 9'(mtf_pkg::TABLE_DEPTH))
                    ? mtf_pkg::idx_t'(mtf_pkg::TABLE_DEPTH - 1)
                    : mtf_pkg::idx_t'(s_tdata);

    // No match only happens when encoding an absent symbol: treat as last slot.
    assign pos_c = root.found ? root.idx : mtf_pkg::idx_t'(mtf_pkg::TABLE_DEPTH - 1);
    assign sym_c = root.found ? root.sym : key_sym_reg;

    always_comb
    begin
        ctl.shift   = commit;
        ctl.clear   = commit && last_reg;
        ctl.decode  = decode_reg;
        ctl.pos     = pos_c;
        ctl.sym     = sym_c;
        ctl.key_sym = key_sym_reg;
        ctl.key_idx = key_idx_reg;
    end

    // Cell row; cell 0 takes the front symbol as its left neighbor.
    genvar k;
    generate
        for (k = 0; k < mtf_pkg::TABLE_DEPTH; k++)
        begin : g_cell
            mtf_pkg::sym_t prev;
            if (k == 0)
            begin : g_front
                assign prev = ctl.sym;
            end
            else
            begin : g_chain
                assign prev = entry[k - 1];
            end

            mtf_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .cell_idx   (mtf_pkg::idx_t'(k)),
                .ctl        (ctl),
                .prev_entry (prev),
                .entry      (entry[k]),
                .match      (match[k])
            );
        end

        for (k = 0; k < mtf_pkg::LEAF_N; k++)
        begin : g_leaf
            if (k < mtf_pkg::TABLE_DEPTH)
            begin : g_live
                assign leaf[k] = '{found: match[k], idx: mtf_pkg::idx_t'(k), sym: entry[k]};
            end
            else
            begin : g_pad
                assign leaf[k] = '{found: 1'b0, idx: '0, sym: '0};
            end
        end
    endgenerate

    mtf_tree u_tree
    (
        .clk  (clk),
        .leaf (leaf),
        .root (root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            decode_reg   <= 1'b0;
            key_sym_reg  <= '0;
            key_idx_reg  <= '0;
            last_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tlast_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                decode_reg <= cfg_data;
            end

            if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        key_sym_reg <= s_tdata;
                        key_idx_reg <= in_idx;
                        last_reg    <= s_tlast;
                        cnt_reg     <= '0;
                        state_reg   <= ST_SEARCH;
                    end
                end
                ST_SEARCH:
                begin
                    if (commit)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= decode_reg ? sym_c : 8'(pos_c);
                        m_tlast_reg  <= last_reg;
                        state_reg    <= ST_IDLE;
                    end
                    else if (cnt_reg != mtf_pkg::cnt_t'(mtf_pkg::IDX_W))
                    begin
                        cnt_reg <= cnt_reg + mtf_pkg::cnt_t'(1);
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

### bench/tb.sv
// Self-checking testbench for the move-to-front coder.
module tb;

    // Values of the mode register.
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Cycles with no accepted item on any channel before the run is abandoned.
    // A correct run never goes quiet for more than a drain pause plus one
    // item's latency and a stall.
    localparam int STALL_LIMIT = 3000;
    // Quiet cycles allowed after the last result and before a register write.
    localparam int SETTLE_CYCLES = 16;

    typedef struct {
        mtf_pkg::sym_t out_byte;
        logic          out_last;
    } mtf_result_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       cfg_data;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // Mirror of the coder: its own symbol table and mode bit.
    mtf_pkg::sym_t mirror_table [mtf_pkg::TABLE_DEPTH];
    logic          mirror_mode;
    mtf_result_t   pending_codes [$];

    int  error_count = 0;
    int  quiet_cycles = 0;
    // When set, neither side inserts idle cycles.
    bit  steady_flow = 1'b0;

    move_to_front_coder DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mirror of the coder
    // ------------------------------------------------------------------

    function automatic void mirror_to_identity();
        for (int k = 0; k < mtf_pkg::TABLE_DEPTH; k++)
        begin
            mirror_table[k] = mtf_pkg::sym_t'(k);
        end
    endfunction

    // Code one byte against the mirror table and update it as the block does.
    function automatic mtf_result_t mtf_code(mtf_pkg::sym_t in_byte, logic block_last);
        mtf_result_t   res;
        int            pos;
        mtf_pkg::sym_t sym;
        if (mirror_mode == MODE_DECODE)
        begin
            // rank past the table end saturates to the last entry
            pos = (int'(in_byte) >= mtf_pkg::TABLE_DEPTH) ? mtf_pkg::TABLE_DEPTH - 1
                                                           : int'(in_byte);
            sym = mirror_table[pos];
            res.out_byte = sym;
        end
        else
        begin
            // lowest matching entry wins; a missing symbol counts as the last one
            sym = in_byte;
            pos = mtf_pkg::TABLE_DEPTH - 1;
            for (int k = mtf_pkg::TABLE_DEPTH - 1; k >= 0; k--)
            begin
                if (mirror_table[k] == sym)
                    pos = k;
            end
            res.out_byte = mtf_pkg::sym_t'(pos);
        end
        for (int k = pos; k > 0; k--)
        begin
            mirror_table[k] = mirror_table[k-1];
        end
        mirror_table[0] = sym;
        res.out_last = block_last;
        if (block_last)
            mirror_to_identity();
        return res;
    endfunction

    // Accepted items and register writes feed the mirror at the rising edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                mirror_mode = cfg_data;
            if (s_tvalid && s_tready)
                pending_codes.push_back(mtf_code(s_tdata, s_tlast));
        end
    end

    // Each result is compared with the oldest expectation.
    always @(posedge clk)
    begin
        mtf_result_t exp_res;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_codes.size() == 0)
            begin
                $error("unexpected result out_byte=%0d out_last=%0d", m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                exp_res = pending_codes.pop_front();
                if (m_tdata !== exp_res.out_byte)
                begin
                    $error("out_byte expected %0d actual %0d", exp_res.out_byte, m_tdata);
                    error_count++;
                end
                if (m_tlast !== exp_res.out_last)
                begin
                    $error("out_last expected %0d actual %0d", exp_res.out_last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Receiver: stalls about one cycle in five unless steady flow is asked.
    always @(negedge clk)
    begin
        m_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 20);
    end

    // Watchdog on cycles where nothing moves on any channel.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared driving tasks; all are entered and left at a falling edge.
    // ------------------------------------------------------------------

    // Offer one item, with random idle cycles ahead of it. Valid stays high
    // afterwards so back-to-back items keep it up; callers that pause drop it.
    task automatic send_item(mtf_pkg::sym_t in_byte, logic block_last);
        while (!steady_flow && $urandom_range(99) < 20)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = in_byte;
        s_tlast  = block_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Hold the sender until every expected result has come back.
    task automatic drain_results();
        s_tvalid = 1'b0;
        while (pending_codes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mode writes only happen with the block idle.
    task automatic write_mode(logic mode);
        drain_results();
        cfg_valid = 1'b1;
        cfg_data  = mode;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // One random byte: a mix of a narrow alphabet (short ranks, deep reuse)
    // and the full range.
    function automatic mtf_pkg::sym_t pick_byte(logic mode, mtf_pkg::sym_t base);
        int roll;
        roll = $urandom_range(99);
        if (mode == MODE_DECODE)
            return (roll < 55) ? mtf_pkg::sym_t'($urandom_range(3))
                               : mtf_pkg::sym_t'($urandom_range(255));
        return (roll < 50) ? mtf_pkg::sym_t'(base + $urandom_range(7))
                           : mtf_pkg::sym_t'($urandom_range(255));
    endfunction

    // Random blocks in the current mode. Most blocks are short; now and then
    // one runs long enough to push symbols deep into the table. The sender
    // pauses once in the middle until all results are back.
    task automatic random_blocks(int n_items);
        int            left;
        int            sent;
        mtf_pkg::sym_t base;
        sent = 0;
        while (sent < n_items)
        begin
            left = ($urandom_range(9) == 0) ? $urandom_range(120, 300) : $urandom_range(1, 24);
            base = mtf_pkg::sym_t'($urandom_range(255));
            while (left > 0 && sent < n_items)
            begin
                left--;
                sent++;
                // a block may stay open across the end of the phase
                send_item(pick_byte(mirror_mode, base), left == 0);
                if (sent == n_items / 2)
                    drain_results();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Encode: field extremes, repeats at rank zero, last marker and the
    // table returning to identity after it.
    task automatic test_encode_directed();
        send_item(8'd0,   1'b0);   // rank 0
        send_item(8'd255, 1'b0);   // rank 255, deepest entry
        send_item(8'd255, 1'b0);   // now at the front
        send_item(8'd0,   1'b0);   // pushed back to rank 1
        send_item(8'd128, 1'b0);
        send_item(8'd1,   1'b1);   // ends the block
        send_item(8'd255, 1'b0);   // identity again: rank 255
        send_item(8'd170, 1'b0);
        send_item(8'd85,  1'b1);
        send_item(8'd255, 1'b1);   // one-item block right after a last
    endtask

    // Decode: rank extremes, rank zero repeats and block boundaries.
    task automatic test_decode_directed();
        write_mode(MODE_DECODE);
        send_item(8'd0,   1'b0);
        send_item(8'd255, 1'b0);   // symbol 255 to the front
        send_item(8'd0,   1'b0);   // 255 again
        send_item(8'd1,   1'b0);
        send_item(8'd255, 1'b0);
        send_item(8'd128, 1'b1);
        send_item(8'd255, 1'b0);   // identity again
        send_item(8'd85,  1'b0);
        send_item(8'd170, 1'b1);
        send_item(8'd0,   1'b1);
    endtask

    task automatic test_encode_random();
        write_mode(MODE_ENCODE);
        random_blocks(110);
    endtask

    task automatic test_decode_random();
        write_mode(MODE_DECODE);
        random_blocks(110);
    endtask

    // A long stretch with neither side idling, in both modes.
    task automatic test_full_rate();
        steady_flow = 1'b1;
        random_blocks(50);
        write_mode(MODE_ENCODE);
        random_blocks(50);
        steady_flow = 1'b0;
    endtask

    // Mode changes left mid-block keep the table; end on encode.
    task automatic test_mode_swaps();
        write_mode(MODE_DECODE);
        random_blocks(30);
        write_mode(MODE_ENCODE);
        random_blocks(30);
        drain_results();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = MODE_ENCODE;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        mirror_mode = MODE_ENCODE;
        mirror_to_identity();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_encode_directed();
        test_decode_directed();
        test_encode_random();
        test_decode_random();
        test_full_rate();
        test_mode_swaps();

        // drain_results has already let the latency pass
        if (error_count == 0 && pending_codes.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
